// ===== design/mlns_pkg.sv =====
package mlns_pkg;

   // Notes kept in the note stack.
   localparam logic [6:0] NOTE_LOW  = 7'd33;
   localparam logic [6:0] NOTE_HIGH = 7'd81;
   localparam int STACK_DEPTH = int'(NOTE_HIGH) - int'(NOTE_LOW) + 1;
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // Depth of the command queue between parser and note stack.
   localparam int QUEUE_DEPTH = 2;

   // Result event codes.
   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_CLOCK    = 4'd1;
   localparam logic [3:0] EV_START    = 4'd2;
   localparam logic [3:0] EV_CONTINUE = 4'd3;
   localparam logic [3:0] EV_STOP     = 4'd4;
   localparam logic [3:0] EV_BEND     = 4'd5;
   localparam logic [3:0] EV_MOD      = 4'd6;
   localparam logic [3:0] EV_CC_SLOT  = 4'd7;
   localparam logic [3:0] EV_ALL_OFF  = 4'd8;
   localparam logic [3:0] EV_PANIC    = 4'd9;

   // Realtime and system bytes.
   localparam logic [7:0] RT_CLOCK    = 8'hF8;
   localparam logic [7:0] RT_START    = 8'hFA;
   localparam logic [7:0] RT_CONTINUE = 8'hFB;
   localparam logic [7:0] RT_STOP     = 8'hFC;
   localparam logic [7:0] RT_SENSE    = 8'hFE;
   localparam logic [7:0] RT_RESET    = 8'hFF;
   localparam logic [7:0] SYSEX_START = 8'hF0;

   // Status kinds (upper nibble of a status byte).
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [3:0] KIND_CTRL     = 4'hB;
   localparam logic [3:0] KIND_PROGRAM  = 4'hC;
   localparam logic [3:0] KIND_PRESSURE = 4'hD;
   localparam logic [3:0] KIND_BEND     = 4'hE;
   localparam logic [3:0] KIND_SYSTEM   = 4'hF;

   // Controller numbers.
   localparam logic [6:0] CC_MOD       = 7'd1;
   localparam logic [6:0] CC_SLOT_LOW  = 7'd75;
   localparam logic [6:0] CC_SLOT_HIGH = 7'd79;
   localparam logic [6:0] CC_ALL_OFF   = 7'd123;

   localparam logic [4:0] CHANNEL_ALL = 5'd16;

   typedef enum logic [1:0] {
      OP_EVENT = 2'd0,
      OP_PUSH  = 2'd1,
      OP_POP   = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  event_res;
      logic [13:0] event_value;
      logic [2:0]  cc_slot;
      logic [6:0]  note;
   } cmd_type;

   typedef struct packed {
      logic       present;
      logic [6:0] note;
   } link_type;

   function automatic logic [IDX_W-1:0] note_index(input logic [6:0] note);
      logic [6:0] diff;
      diff = note - NOTE_LOW;
      return diff[IDX_W-1:0];
   endfunction

endpackage

// ===== design/midi_parser_last_note_stack.sv =====
// MIDI receive parser with a last-note-priority note stack. Each item on the
// req_ channel is one received byte (with the receiver's overrun flag) or a
// panic request, and every item gives exactly one item on the rsp_ channel:
// an event code with its value and controller slot, plus the most recently
// pressed note that is still held. Clock, start, continue and stop bytes give
// events without disturbing the running-status parser; system-exclusive data
// is skipped. Channel messages pass the channel filter in csr_own_channel
// (0..15, or 16 for every channel; it resets to 16 and should be written only
// while the block is idle). Notes 33 to 81 are kept in the stack; note-on with
// velocity zero releases a note, and CC123 or a panic empties the stack.
// Items that do not touch the note stack are taken one per clock unless the
// queue is full or the result waits; a note-on or note-off inside the stack
// range occupies the stack unit while it first reads the note's two link-table
// entries and then rewrites the neighbors' links. Each command passes through
// the command queue and the result register, a note command also through the
// update state. The stack is empty right after reset with no clearing pass.
module midi_parser_last_note_stack (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_overrun,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_event_res,
   output logic [13:0] rsp_event_value,
   output logic [2:0]  rsp_cc_slot,
   output logic [6:0]  rsp_mono_note,
   output logic        rsp_mono_valid,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_own_channel
);
   import mlns_pkg::*;

   // The parser turns each item into a stack command; the queue lets the
   // parser keep taking bytes while the stack unit is busy with a note.
   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;
   logic    back_valid;
   logic    back_ready;
   cmd_type back_cmd;

   mlns_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .req_overrun     (req_overrun),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_own_channel (csr_own_channel),
      .cmd_valid       (front_valid),
      .cmd_ready       (front_ready),
      .cmd             (front_cmd)
   );

   mlns_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_cmd   (front_cmd),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_cmd   (back_cmd)
   );

   // The stack unit applies the command and holds the result in an output
   // register until it is taken.
   mlns_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (back_valid),
      .cmd_ready       (back_ready),
      .cmd             (back_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_event_value (rsp_event_value),
      .rsp_cc_slot     (rsp_cc_slot),
      .rsp_mono_note   (rsp_mono_note),
      .rsp_mono_valid  (rsp_mono_valid)
   );

endmodule

// ===== design/mlns_ram.sv =====
module mlns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/mlns_front.sv =====
module mlns_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_overrun,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_own_channel,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output mlns_pkg::cmd_type cmd
);
   import mlns_pkg::*;

   typedef enum logic [4:0] {
      MODE_RESET  = 5'b00001,
      MODE_SYSEX  = 5'b00010,
      MODE_ONE    = 5'b00100,
      MODE_FIRST  = 5'b01000,
      MODE_SECOND = 5'b10000
   } mode_type;

   logic [7:0] status_ff, status_in;
   mode_type   mode_ff, mode_in;
   logic [6:0] first_ff, first_in;
   logic [4:0] own_ff;
   logic [3:0] kind;
   logic [6:0] data;
   logic       chan_ok;
   logic       note_ok;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign csr_ready = 1'b1;
   assign data      = req_rx_byte[6:0];
   assign note_ok   = (first_ff >= NOTE_LOW) && (first_ff <= NOTE_HIGH);

   always_comb begin
      status_in       = status_ff;
      mode_in         = mode_ff;
      first_in        = first_ff;
      cmd.op          = OP_EVENT;
      cmd.event_res   = EV_NONE;
      cmd.event_value = '0;
      cmd.cc_slot     = '0;
      cmd.note        = first_ff;
      kind            = '0;
      chan_ok         = 1'b0;

      // An overrun drops running status before the byte is looked at.
      if (req_overrun) begin
         status_in = '0;
         mode_in   = MODE_RESET;
      end

      if (req_action) begin
         status_in     = '0;
         mode_in       = MODE_RESET;
         cmd.op        = OP_CLEAR;
         cmd.event_res = EV_PANIC;
      end else begin
         case (req_rx_byte)
            RT_CLOCK:    cmd.event_res = EV_CLOCK;
            RT_START:    cmd.event_res = EV_START;
            RT_CONTINUE: cmd.event_res = EV_CONTINUE;
            RT_STOP:     cmd.event_res = EV_STOP;
            RT_SENSE, RT_RESET: begin
            end
            default: begin
               if (req_rx_byte[7]) begin
                  status_in = req_rx_byte;
                  case (req_rx_byte[7:4])
                     KIND_SYSTEM: begin
                        mode_in = (req_rx_byte == SYSEX_START) ? MODE_SYSEX : MODE_RESET;
                     end
                     KIND_PROGRAM, KIND_PRESSURE: mode_in = MODE_ONE;
                     default:                     mode_in = MODE_FIRST;
                  endcase
               end else begin
                  kind    = status_in[7:4];
                  chan_ok = (own_ff == CHANNEL_ALL) || (own_ff == {1'b0, status_in[3:0]});
                  if (kind != KIND_SYSTEM) begin
                     case (mode_in)
                        MODE_FIRST: begin
                           first_in = data;
                           mode_in  = MODE_SECOND;
                        end
                        MODE_SECOND: begin
                           mode_in = MODE_FIRST;
                           if (chan_ok) begin
                              case (kind)
                                 KIND_BEND: begin
                                    cmd.event_res   = EV_BEND;
                                    cmd.event_value = {data, first_ff};
                                 end
                                 KIND_CTRL: begin
                                    if (first_ff == CC_MOD) begin
                                       cmd.event_res   = EV_MOD;
                                       cmd.event_value = {7'd0, data};
                                    end else if (first_ff inside {[CC_SLOT_LOW:CC_SLOT_HIGH]}) begin
                                       cmd.event_res   = EV_CC_SLOT;
                                       cmd.event_value = {7'd0, data};
                                       cmd.cc_slot     = 3'(first_ff - CC_SLOT_LOW);
                                    end else if (first_ff == CC_ALL_OFF) begin
                                       cmd.op        = OP_CLEAR;
                                       cmd.event_res = EV_ALL_OFF;
                                    end
                                 end
                                 KIND_NOTE_ON: begin
                                    // Velocity zero is a note-off.
                                    if (note_ok) begin
                                       cmd.op = (data == 7'd0) ? OP_POP : OP_PUSH;
                                    end
                                 end
                                 KIND_NOTE_OFF: begin
                                    if (note_ok) begin
                                       cmd.op = OP_POP;
                                    end
                                 end
                                 default: begin
                                 end
                              endcase
                           end
                        end
                        default: begin
                        end
                     endcase
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= '0;
         mode_ff   <= MODE_RESET;
         first_ff  <= '0;
         own_ff    <= CHANNEL_ALL;
      end else begin
         if (req_valid && req_ready) begin
            status_ff <= status_in;
            mode_ff   <= mode_in;
            first_ff  <= first_in;
         end
         if (csr_valid) begin
            own_ff <= csr_own_channel;
         end
      end
   end

endmodule

// ===== design/mlns_queue.sv =====
module mlns_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  mlns_pkg::cmd_type wr_cmd,
   output logic              rd_valid,
   input  logic              rd_ready,
   output mlns_pkg::cmd_type rd_cmd
);
   import mlns_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

// ===== design/mlns_back.sv =====
module mlns_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mlns_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_event_res,
   output logic [13:0]       rsp_event_value,
   output logic [2:0]        rsp_cc_slot,
   output logic [6:0]        rsp_mono_note,
   output logic              rsp_mono_valid
);
   import mlns_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          cmd_ff;
   logic             top_vld_ff, top_vld_in;
   logic [6:0]       top_note_ff, top_note_in;
   logic [STACK_DEPTH-1:0] next_vld_ff;
   logic [STACK_DEPTH-1:0] prev_vld_ff;

   logic             rsp_valid_ff;
   logic [3:0]       rsp_event_res_ff, rsp_event_res_in;
   logic [13:0]      rsp_event_value_ff, rsp_event_value_in;
   logic [2:0]       rsp_cc_slot_ff, rsp_cc_slot_in;
   logic [6:0]       rsp_mono_note_ff;
   logic             rsp_mono_valid_ff;

   logic             out_free;
   logic             take;
   logic             is_note;
   logic             load_out;
   logic             clear_all;
   logic             top_hit;
   logic [IDX_W-1:0] note_idx;
   logic [6:0]       next_rd;
   logic [6:0]       prev_rd;
   link_type         next_lk;
   link_type         prev_lk;

   // One link write and one link clear per table and cycle.
   logic             nx_wr_en, pv_wr_en;
   logic [IDX_W-1:0] nx_wr_idx, pv_wr_idx;
   link_type         nx_wr_lk, pv_wr_lk;
   logic             nx_clr_en, pv_clr_en;
   logic [IDX_W-1:0] nx_clr_idx, pv_clr_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;
   assign take      = cmd_valid && cmd_ready;
   assign is_note   = (cmd.op == OP_PUSH) || (cmd.op == OP_POP);
   assign note_idx  = note_index(cmd_ff.note);
   assign top_hit   = top_vld_ff && (top_note_ff == cmd_ff.note);

   // An entry whose valid bit is clear reads as no link.
   assign next_lk.present = next_vld_ff[note_idx];
   assign next_lk.note    = next_rd;
   assign prev_lk.present = prev_vld_ff[note_idx];
   assign prev_lk.note    = prev_rd;

   mlns_ram #(
      .WIDTH (7),
      .DEPTH (STACK_DEPTH)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (nx_wr_en && nx_wr_lk.present),
      .wr_addr (nx_wr_idx),
      .wr_data (nx_wr_lk.note),
      .rd_en   (take && is_note),
      .rd_addr (note_index(cmd.note)),
      .rd_data (next_rd)
   );

   mlns_ram #(
      .WIDTH (7),
      .DEPTH (STACK_DEPTH)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (pv_wr_en && pv_wr_lk.present),
      .wr_addr (pv_wr_idx),
      .wr_data (pv_wr_lk.note),
      .rd_en   (take && is_note),
      .rd_addr (note_index(cmd.note)),
      .rd_data (prev_rd)
   );

   always_comb begin
      state_in           = state_ff;
      top_vld_in         = top_vld_ff;
      top_note_in        = top_note_ff;
      load_out           = 1'b0;
      clear_all          = 1'b0;
      rsp_event_res_in   = cmd.event_res;
      rsp_event_value_in = cmd.event_value;
      rsp_cc_slot_in     = cmd.cc_slot;
      nx_wr_en           = 1'b0;
      nx_wr_idx          = '0;
      nx_wr_lk           = '0;
      pv_wr_en           = 1'b0;
      pv_wr_idx          = '0;
      pv_wr_lk           = '0;
      nx_clr_en          = 1'b0;
      nx_clr_idx         = note_idx;
      pv_clr_en          = 1'b0;
      pv_clr_idx         = note_idx;

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (is_note) begin
                  state_in = ST_UPDATE;
               end else begin
                  load_out = 1'b1;
                  if (cmd.op == OP_CLEAR) begin
                     clear_all  = 1'b1;
                     top_vld_in = 1'b0;
                  end
               end
            end
         end
         ST_UPDATE: begin
            state_in           = ST_IDLE;
            load_out           = 1'b1;
            rsp_event_res_in   = cmd_ff.event_res;
            rsp_event_value_in = cmd_ff.event_value;
            rsp_cc_slot_in     = cmd_ff.cc_slot;
            if (cmd_ff.op == OP_PUSH) begin
               // A note already held is left where it is.
               if (!(top_hit || prev_lk.present || next_lk.present)) begin
                  if (top_vld_ff) begin
                     nx_wr_en         = 1'b1;
                     nx_wr_idx        = note_index(top_note_ff);
                     nx_wr_lk.present = 1'b1;
                     nx_wr_lk.note    = cmd_ff.note;
                     pv_wr_en         = 1'b1;
                     pv_wr_idx        = note_idx;
                     pv_wr_lk.present = 1'b1;
                     pv_wr_lk.note    = top_note_ff;
                  end
                  top_vld_in  = 1'b1;
                  top_note_in = cmd_ff.note;
               end
            end else if (top_hit) begin
               // Releasing the top note: the one below becomes the top.
               top_vld_in  = prev_lk.present;
               top_note_in = prev_lk.note;
               pv_clr_en   = 1'b1;
               if (prev_lk.present) begin
                  nx_wr_en  = 1'b1;
                  nx_wr_idx = note_index(prev_lk.note);
                  nx_wr_lk  = '0;
               end
            end else begin
               // Unlink a note from the middle or the bottom of the stack.
               if (prev_lk.present) begin
                  nx_wr_en  = 1'b1;
                  nx_wr_idx = note_index(prev_lk.note);
                  nx_wr_lk  = next_lk;
               end
               if (next_lk.present) begin
                  pv_wr_en  = 1'b1;
                  pv_wr_idx = note_index(next_lk.note);
                  pv_wr_lk  = prev_lk;
               end
               nx_clr_en = 1'b1;
               pv_clr_en = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_vld_ff   <= 1'b0;
         next_vld_ff  <= '0;
         prev_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         top_vld_ff <= top_vld_in;
         if (clear_all) begin
            next_vld_ff <= '0;
            prev_vld_ff <= '0;
         end else begin
            if (nx_wr_en) begin
               next_vld_ff[nx_wr_idx] <= nx_wr_lk.present;
            end
            if (nx_clr_en) begin
               next_vld_ff[nx_clr_idx] <= 1'b0;
            end
            if (pv_wr_en) begin
               prev_vld_ff[pv_wr_idx] <= pv_wr_lk.present;
            end
            if (pv_clr_en) begin
               prev_vld_ff[pv_clr_idx] <= 1'b0;
            end
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_note_ff <= top_note_in;
      if (take) begin
         cmd_ff <= cmd;
      end
      if (load_out) begin
         rsp_event_res_ff   <= rsp_event_res_in;
         rsp_event_value_ff <= rsp_event_value_in;
         rsp_cc_slot_ff     <= rsp_cc_slot_in;
         rsp_mono_valid_ff  <= top_vld_in;
         rsp_mono_note_ff   <= top_vld_in ? top_note_in : 7'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_res_ff;
   assign rsp_event_value = rsp_event_value_ff;
   assign rsp_cc_slot     = rsp_cc_slot_ff;
   assign rsp_mono_note   = rsp_mono_note_ff;
   assign rsp_mono_valid  = rsp_mono_valid_ff;

endmodule

// ===== dv/midi_parser_last_note_stack_tb.sv =====
module midi_parser_last_note_stack_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mlns_pkg::*;

   // Marks an empty link-table entry and an empty stack.
   localparam logic [7:0] NO_LINK = 8'hFF;

   // Parser modes of the predictor.
   typedef enum logic [2:0] {
      PS_RESET,
      PS_SYSEX,
      PS_ONE_DATA,
      PS_FIRST_DATA,
      PS_SECOND_DATA
   } parse_state_type;

   // One result item as the block should report it.
   typedef struct packed {
      logic [3:0]  event_res;
      logic [13:0] event_value;
      logic [2:0]  cc_slot;
      logic [6:0]  mono_note;
      logic        mono_valid;
   } note_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_overrun = 1'b0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_res;
   logic [13:0] rsp_event_value;
   logic [2:0]  rsp_cc_slot;
   logic [6:0]  rsp_mono_note;
   logic        rsp_mono_valid;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_own_channel = 5'd0;

   // Predictor state: channel filter, running-status parser and the note stack
   // kept as two link tables, indexed by the full note number.
   logic [4:0]      filter_channel;
   logic [7:0]      run_status;
   parse_state_type parse_state;
   logic [6:0]      first_data_byte;
   logic [7:0]      next_note [0:127];
   logic [7:0]      prev_note [0:127];
   logic [7:0]      top_of_stack;

   // Results predicted for accepted items, oldest first.
   note_result_type expected_results [$];

   int error_count = 0;
   int items_sent = 0;
   int send_idle_pct = 19;
   int recv_stall_pct = 54;

   midi_parser_last_note_stack dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .req_overrun     (req_overrun),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_event_res   (rsp_event_res),
      .rsp_event_value (rsp_event_value),
      .rsp_cc_slot     (rsp_cc_slot),
      .rsp_mono_note   (rsp_mono_note),
      .rsp_mono_valid  (rsp_mono_valid),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_own_channel (csr_own_channel)
   );

   always #5 clock = ~clock;

   // Empties the note stack: every link is dropped and there is no top.
   function automatic void clear_note_stack();
      foreach (next_note[i]) begin
         next_note[i] = NO_LINK;
         prev_note[i] = NO_LINK;
      end
      top_of_stack = NO_LINK;
   endfunction

   // Advances the predicted parser and note stack by one item and returns the
   // result item that the block must give for it.
   function automatic note_result_type predict_midi_result(input logic act,
                                                           input logic [7:0] b,
                                                           input logic ovr);
      note_result_type r;
      logic [3:0]      kind;
      logic [6:0]      d1;
      logic [6:0]      d2;
      logic [7:0]      p;
      logic [7:0]      q;
      logic            deliver;
      r = '0;
      kind = '0;
      d1 = '0;
      d2 = '0;
      deliver = 1'b0;
      if (act) begin
         // A panic wipes the stack and the parser, whatever the byte says.
         clear_note_stack();
         run_status = '0;
         parse_state = PS_RESET;
         r.event_res = EV_PANIC;
      end else begin
         // An overrun drops running status before the byte is looked at.
         if (ovr) begin
            run_status = '0;
            parse_state = PS_RESET;
         end
         case (b)
            RT_CLOCK:          r.event_res = EV_CLOCK;
            RT_START:          r.event_res = EV_START;
            RT_CONTINUE:       r.event_res = EV_CONTINUE;
            RT_STOP:           r.event_res = EV_STOP;
            RT_SENSE, RT_RESET: ;
            default: begin
               if (b[7]) begin
                  run_status = b;
                  if (b == SYSEX_START)
                     parse_state = PS_SYSEX;
                  else if (b[7:4] == KIND_SYSTEM)
                     parse_state = PS_RESET;
                  else if (b[7:4] == KIND_PROGRAM || b[7:4] == KIND_PRESSURE)
                     parse_state = PS_ONE_DATA;
                  else
                     parse_state = PS_FIRST_DATA;
               end else if (parse_state != PS_RESET && parse_state != PS_SYSEX &&
                            run_status[7:4] != KIND_SYSTEM) begin
                  kind = run_status[7:4];
                  if (parse_state == PS_FIRST_DATA) begin
                     first_data_byte = b[6:0];
                     parse_state = PS_SECOND_DATA;
                  end else if (parse_state == PS_SECOND_DATA) begin
                     d1 = first_data_byte;
                     d2 = b[6:0];
                     // A note-on with velocity zero releases the note.
                     if (kind == KIND_NOTE_ON && d2 == 7'd0)
                        kind = KIND_NOTE_OFF;
                     deliver = 1'b1;
                     parse_state = PS_FIRST_DATA;
                  end else begin
                     d1 = b[6:0];
                     deliver = 1'b1;
                  end
                  deliver = deliver && (filter_channel == CHANNEL_ALL ||
                                        filter_channel == {1'b0, run_status[3:0]});
               end
            end
         endcase
      end
      if (deliver) begin
         case (kind)
            KIND_BEND: begin
               r.event_res = EV_BEND;
               r.event_value = {d2, d1};
            end
            KIND_CTRL: begin
               if (d1 == CC_MOD) begin
                  r.event_res = EV_MOD;
                  r.event_value = {7'd0, d2};
               end else if (d1 >= CC_SLOT_LOW && d1 <= CC_SLOT_HIGH) begin
                  r.event_res = EV_CC_SLOT;
                  r.event_value = {7'd0, d2};
                  r.cc_slot = 3'(d1 - CC_SLOT_LOW);
               end else if (d1 == CC_ALL_OFF) begin
                  clear_note_stack();
                  r.event_res = EV_ALL_OFF;
               end
            end
            KIND_NOTE_ON: begin
               // A note already held stays where it is in the stack.
               if (d1 >= NOTE_LOW && d1 <= NOTE_HIGH && top_of_stack != {1'b0, d1} &&
                   prev_note[d1] == NO_LINK && next_note[d1] == NO_LINK) begin
                  if (top_of_stack != NO_LINK)
                     next_note[top_of_stack[6:0]] = {1'b0, d1};
                  prev_note[d1] = top_of_stack;
                  next_note[d1] = NO_LINK;
                  top_of_stack = {1'b0, d1};
               end
            end
            KIND_NOTE_OFF: begin
               if (d1 >= NOTE_LOW && d1 <= NOTE_HIGH) begin
                  p = prev_note[d1];
                  q = next_note[d1];
                  if (top_of_stack == {1'b0, d1}) begin
                     top_of_stack = p;
                     if (p != NO_LINK)
                        next_note[p[6:0]] = NO_LINK;
                  end else begin
                     // Unlink from the middle; a note not held has no links.
                     if (p != NO_LINK)
                        next_note[p[6:0]] = q;
                     if (q != NO_LINK)
                        prev_note[q[6:0]] = p;
                  end
                  prev_note[d1] = NO_LINK;
                  next_note[d1] = NO_LINK;
               end
            end
            default: ;
         endcase
      end
      if (top_of_stack != NO_LINK && top_of_stack[6:0] >= NOTE_LOW &&
          top_of_stack[6:0] <= NOTE_HIGH) begin
         r.mono_note = top_of_stack[6:0];
         r.mono_valid = 1'b1;
      end
      return r;
   endfunction

   // Receiver: stalls at random at the current rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Every result item is checked against the oldest prediction.
   always @(posedge clock) begin : check_results
      note_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with no prediction waiting");
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_event_res !== want.event_res) begin
               $error("event_res: expected %0d, got %0d", want.event_res, rsp_event_res);
               error_count++;
            end
            if (rsp_event_value !== want.event_value) begin
               $error("event_value: expected %0d, got %0d",
                      want.event_value, rsp_event_value);
               error_count++;
            end
            if (rsp_cc_slot !== want.cc_slot) begin
               $error("cc_slot: expected %0d, got %0d", want.cc_slot, rsp_cc_slot);
               error_count++;
            end
            if (rsp_mono_note !== want.mono_note) begin
               $error("mono_note: expected %0d, got %0d", want.mono_note, rsp_mono_note);
               error_count++;
            end
            if (rsp_mono_valid !== want.mono_valid) begin
               $error("mono_valid: expected %0d, got %0d",
                      want.mono_valid, rsp_mono_valid);
               error_count++;
            end
         end
      end
   end

   // Offers one item, holds it until the block takes it, then predicts its
   // result. The valid is left high so that a following item can go out on
   // the very next edge; whoever stops sending lowers it.
   task automatic send_item(input logic act, input logic [7:0] b, input logic ovr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_rx_byte <= b;
      req_overrun <= ovr;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_results.push_back(predict_midi_result(act, b, ovr));
      items_sent++;
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   // Writes the channel filter; only done with the block drained.
   task automatic write_own_channel(input logic [4:0] chan);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_own_channel <= chan;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      filter_channel = chan;
   endtask

   function automatic logic [7:0] random_realtime_byte();
      case ($urandom_range(0, 5))
         0:       return RT_CLOCK;
         1:       return RT_START;
         2:       return RT_CONTINUE;
         3:       return RT_STOP;
         4:       return RT_SENSE;
         default: return RT_RESET;
      endcase
   endfunction

   // A status byte, skipped at times when running status already covers it.
   task automatic send_status(input logic [7:0] status);
      if (!(run_status == status && $urandom_range(0, 2) != 0 &&
            (parse_state == PS_FIRST_DATA || parse_state == PS_ONE_DATA)))
         send_item(1'b0, status, $urandom_range(0, 99) < 3);
   endtask

   // A data byte, now and then preceded by a realtime byte or hit by an overrun.
   task automatic send_data(input logic [6:0] d);
      if ($urandom_range(0, 19) == 0)
         send_item(1'b0, random_realtime_byte(), 1'b0);
      send_item(1'b0, {1'b0, d}, $urandom_range(0, 99) < 2);
   endtask

   // One random message. Most of them are well-formed channel messages, mostly
   // on low notes so that the stack grows deep and notes leave from its middle;
   // the rest are system traffic, realtime bytes, noise and panics.
   task automatic send_random_message(input logic [4:0] chan);
      int unsigned sel;
      int unsigned pick;
      logic [3:0]  ch;
      logic [6:0]  num;
      sel = $urandom_range(0, 99);
      if (chan < CHANNEL_ALL && $urandom_range(0, 3) != 0)
         ch = chan[3:0];
      else
         ch = 4'($urandom_range(0, 15));
      if (sel < 45) begin
         pick = $urandom_range(0, 99);
         if (pick < 75)
            num = 7'($urandom_range(33, 46));
         else if (pick < 95)
            num = 7'($urandom_range(NOTE_LOW, NOTE_HIGH));
         else
            num = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 99) < 55) begin
            send_status({KIND_NOTE_ON, ch});
            send_data(num);
            send_data(($urandom_range(0, 99) < 15) ? 7'd0 : 7'($urandom_range(1, 127)));
         end else begin
            send_status({KIND_NOTE_OFF, ch});
            send_data(num);
            send_data(7'($urandom_range(0, 127)));
         end
      end else if (sel < 60) begin
         pick = $urandom_range(0, 9);
         if (pick < 2)
            num = CC_MOD;
         else if (pick < 6)
            num = 7'($urandom_range(CC_SLOT_LOW, CC_SLOT_HIGH));
         else if (pick == 6)
            num = CC_ALL_OFF;
         else
            num = 7'($urandom_range(0, 127));
         send_status({KIND_CTRL, ch});
         send_data(num);
         send_data(7'($urandom_range(0, 127)));
      end else if (sel < 70) begin
         send_status({KIND_BEND, ch});
         send_data(7'($urandom_range(0, 127)));
         send_data(7'($urandom_range(0, 127)));
      end else if (sel < 78) begin
         send_status({($urandom_range(0, 1) ? KIND_PROGRAM : KIND_PRESSURE), ch});
         repeat ($urandom_range(1, 2))
            send_data(7'($urandom_range(0, 127)));
      end else if (sel < 85) begin
         if ($urandom_range(0, 1)) begin
            send_item(1'b0, SYSEX_START, 1'b0);
         end else begin
            // Any other system common byte, which puts the parser in reset mode.
            pick = $urandom_range(0, 8);
            if (pick < 7)
               send_item(1'b0, {KIND_SYSTEM, 4'(pick + 1)}, 1'b0);
            else
               send_item(1'b0, {KIND_SYSTEM, (pick == 7) ? 4'h9 : 4'hD}, 1'b0);
         end
         repeat ($urandom_range(0, 4))
            send_data(7'($urandom_range(0, 127)));
      end else if (sel < 90) begin
         send_item(1'b0, random_realtime_byte(), $urandom_range(0, 9) == 0);
      end else if (sel < 95) begin
         send_item(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (sel < 97) begin
         send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
         // A note-on whose status byte comes right after an overrun.
         send_item(1'b0, {KIND_NOTE_ON, ch}, 1'b1);
         send_data(7'($urandom_range(33, 46)));
         send_data(7'($urandom_range(1, 127)));
      end
   endtask

   // Random messages under one channel setting until the count is reached.
   task automatic run_traffic(input logic [4:0] chan, input int send_pct, input int recv_pct,
                              input int count);
      int start;
      write_own_channel(chan);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      start = items_sent;
      while (items_sent - start < count)
         send_random_message(chan);
   endtask

   // Clock, start, continue and stop give events; active sensing and system
   // reset give none, the reset byte here with an overrun flag attached.
   task automatic test_realtime_bytes();
      send_item(1'b0, RT_CLOCK, 1'b0);
      send_item(1'b0, RT_START, 1'b0);
      send_item(1'b0, RT_CONTINUE, 1'b0);
      send_item(1'b0, RT_STOP, 1'b0);
      send_item(1'b0, RT_SENSE, 1'b0);
      send_item(1'b0, RT_RESET, 1'b1);
   endtask

   // Pushes both range limits, retriggers a held note, tries a note just
   // above the range, then releases the top by velocity zero.
   task automatic test_note_stack();
      send_item(1'b0, {KIND_NOTE_ON, 4'h0}, 1'b0);
      send_data(NOTE_LOW);
      send_data(7'd127);
      send_data(NOTE_HIGH);
      send_data(7'd1);
      send_data(NOTE_LOW);
      send_data(7'd64);
      send_data(NOTE_HIGH + 7'd1);
      send_data(7'd1);
      send_data(NOTE_HIGH);
      send_data(7'd0);
   endtask

   // Highest controller slot on the highest channel, all notes off while a
   // note is held, and the largest pitch bend.
   task automatic test_controllers();
      send_item(1'b0, {KIND_CTRL, 4'hF}, 1'b0);
      send_data(CC_SLOT_HIGH);
      send_data(7'd127);
      send_data(CC_ALL_OFF);
      send_data(7'd0);
      send_item(1'b0, {KIND_BEND, 4'hF}, 1'b0);
      send_data(7'd127);
      send_data(7'd127);
   endtask

   // Data inside system exclusive is skipped; a panic clears everything and
   // the data byte after it is ignored in reset mode.
   task automatic test_system_and_panic();
      send_item(1'b0, {KIND_NOTE_ON, 4'h3}, 1'b0);
      send_data(7'd40);
      send_data(7'd99);
      send_item(1'b0, SYSEX_START, 1'b0);
      send_data(7'h12);
      send_item(1'b1, 8'hFF, 1'b1);
      send_data(7'h40);
   endtask

   // The filter passes one channel (0 and 15 here) or, above 16, none.
   task automatic test_channel_filter();
      run_traffic(5'd0, 19, 54, 120);
      run_traffic(5'd15, 19, 54, 120);
      run_traffic(5'd31, 54, 19, 80);
      run_traffic(5'd17, 54, 19, 60);
   endtask

   task automatic test_random_traffic();
      run_traffic(CHANNEL_ALL, 54, 19, 200);
      run_traffic(5'd7, 0, 0, 150);
      run_traffic(CHANNEL_ALL, 0, 0, 200);
   endtask

   initial begin
      filter_channel = CHANNEL_ALL;
      run_status = '0;
      parse_state = PS_RESET;
      first_data_byte = '0;
      clear_note_stack();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_realtime_bytes();
      test_note_stack();
      test_controllers();
      test_system_and_panic();
      test_channel_filter();
      test_random_traffic();

      // Drain, then give any stray result item time to show up.
      wait_for_results();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("** midi_parser_last_note_stack: PASSED **");
      else
         $display("** midi_parser_last_note_stack: FAILED **");
      $finish;
   end

   // A stuck handshake ends the run here.
   initial begin
      #5_000_000;
      $display("** midi_parser_last_note_stack: FAILED **");
      $finish;
   end

endmodule
